FILE: rtl/lpsd_pkg.sv
// Package: codes, widths and beat types for the length-prefixed stream deframer.
`timescale 1ns / 1ps
package lpsd_pkg;

  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 3;
  localparam int TOTAL_W    = 32;
  localparam int LEN_W      = 32;
  localparam int FLEN_W     = 16;
  localparam int IDLE_W     = 24;
  localparam int HIDX_W     = 2;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL  = 2'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

  localparam logic [KIND_W-1:0] ST_BYTE    = 3'd0;
  localparam logic [KIND_W-1:0] ST_END     = 3'd1;
  localparam logic [KIND_W-1:0] ST_REMOTE  = 3'd2;
  localparam logic [KIND_W-1:0] ST_PROTO   = 3'd3;
  localparam logic [KIND_W-1:0] ST_TIMEOUT = 3'd4;
  localparam logic [KIND_W-1:0] ST_CANCEL  = 3'd5;

  localparam logic [PHASE_W-1:0] PH_LEN  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_PAY  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BUDGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd1;

  localparam logic [IDLE_W-1:0] IDLE_MAX          = {IDLE_W{1'b1}};
  localparam logic [LEN_W-1:0]  FAIL_MARK         = {LEN_W{1'b1}};
  localparam logic [IDLE_W-1:0] IDLE_BUDGET_RESET = 24'd30000;
  localparam logic [FLEN_W-1:0] MAX_LEN_RESET     = 16'd1024;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0]  status_kind;
    logic [BYTE_W-1:0]  payload_byte;
    logic               frame_end;
    logic [TOTAL_W-1:0] committed_bytes;
  } out_beat_t;

  typedef struct packed {
    logic [IDLE_W-1:0] idle_budget_ticks;
    logic [FLEN_W-1:0] max_frame_length;
  } cfg_t;

endpackage

FILE: rtl/lpsd_if.sv
// Interfaces: input, result and configuration channels of the deframer.
`timescale 1ns / 1ps
interface lpsd_in_if;
  logic                         valid;
  logic                         ready;
  logic [lpsd_pkg::OP_W-1:0]    opcode;
  logic [lpsd_pkg::BYTE_W-1:0]  data_byte;
  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface lpsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpsd_pkg::KIND_W-1:0]   status_kind;
  logic [lpsd_pkg::BYTE_W-1:0]   payload_byte;
  logic                          frame_end;
  logic [lpsd_pkg::TOTAL_W-1:0]  committed_bytes;
  modport source (output valid, output status_kind, output payload_byte,
                  output frame_end, output committed_bytes, input ready);
  modport sink (input valid, input status_kind, input payload_byte,
                input frame_end, input committed_bytes, output ready);
endinterface

interface lpsd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lpsd_pkg::CFG_IDX_W-1:0]  idx;
  logic [lpsd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

FILE: rtl/lpsd_cfg.sv
// Configuration registers: idle budget and maximum frame length.
`timescale 1ns / 1ps
module lpsd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_valid,
  input  logic [lpsd_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  logic [lpsd_pkg::CFG_DATA_W-1:0] wr_data,
  output logic                            wr_ready,
  output lpsd_pkg::cfg_t                  cfg
);

  lpsd_pkg::cfg_t cfg_r;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_budget_ticks <= lpsd_pkg::IDLE_BUDGET_RESET;
      cfg_r.max_frame_length  <= lpsd_pkg::MAX_LEN_RESET;
    end else if (wr_valid) begin
      unique case (wr_idx)
        lpsd_pkg::CFG_IDLE_BUDGET: cfg_r.idle_budget_ticks <= wr_data;
        lpsd_pkg::CFG_MAX_LEN:     cfg_r.max_frame_length  <= wr_data[lpsd_pkg::FLEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/lpsd_in_stage.sv
// Input register: holds one accepted beat until the core consumes it.
`timescale 1ns / 1ps
module lpsd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  lpsd_pkg::in_beat_t  in_beat,
  output logic                in_ready,
  input  logic                take,
  output logic                beat_valid,
  output lpsd_pkg::in_beat_t  beat
);

  logic               valid_r;
  lpsd_pkg::in_beat_t beat_r;

  assign in_ready   = !valid_r || take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_beat;
    end
  end

endmodule

FILE: rtl/lpsd_core.sv
// Deframer core: stream state, per-beat decode and result register.
`timescale 1ns / 1ps
module lpsd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  lpsd_pkg::cfg_t      cfg,
  input  logic                beat_valid,
  input  lpsd_pkg::in_beat_t  beat,
  output logic                take,
  output logic                out_valid,
  output lpsd_pkg::out_beat_t out_beat,
  input  logic                out_ready
);

  logic [lpsd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [lpsd_pkg::HIDX_W-1:0]  hidx_r, hidx_nxt;
  logic [lpsd_pkg::LEN_W-1:0]   acc_r, acc_nxt, acc_new;
  logic [lpsd_pkg::FLEN_W-1:0]  rem_r, rem_nxt, rem_dec;
  logic [lpsd_pkg::FLEN_W-1:0]  flen_r, flen_nxt;
  logic [lpsd_pkg::IDLE_W-1:0]  idle_r, idle_nxt, idle_sat;
  logic [lpsd_pkg::TOTAL_W-1:0] total_r, total_nxt;

  logic                 emit;
  lpsd_pkg::out_beat_t  res;
  logic                 out_valid_r;
  lpsd_pkg::out_beat_t  out_r;

  assign take      = beat_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    flen_nxt  = flen_r;
    idle_nxt  = idle_r;
    total_nxt = total_r;
    emit      = 1'b0;
    res.status_kind     = lpsd_pkg::ST_BYTE;
    res.payload_byte    = '0;
    res.frame_end       = 1'b0;
    res.committed_bytes = total_r;

    acc_new = acc_r;
    acc_new[hidx_r*lpsd_pkg::BYTE_W +: lpsd_pkg::BYTE_W] =
      acc_r[hidx_r*lpsd_pkg::BYTE_W +: lpsd_pkg::BYTE_W] | beat.data_byte;
    rem_dec  = rem_r - 1'b1;
    idle_sat = (idle_r == lpsd_pkg::IDLE_MAX) ? idle_r : idle_r + 1'b1;

    if (beat.opcode == lpsd_pkg::OP_RESTART) begin
      phase_nxt = lpsd_pkg::PH_LEN;
      hidx_nxt  = '0;
      acc_nxt   = '0;
      rem_nxt   = '0;
      flen_nxt  = '0;
      idle_nxt  = '0;
      total_nxt = '0;
    end else if (phase_r != lpsd_pkg::PH_DONE) begin
      case (beat.opcode)
        lpsd_pkg::OP_CANCEL: begin
          emit            = 1'b1;
          res.status_kind = lpsd_pkg::ST_CANCEL;
          phase_nxt       = lpsd_pkg::PH_DONE;
        end
        lpsd_pkg::OP_TICK: begin
          idle_nxt = idle_sat;
          if (idle_sat >= cfg.idle_budget_ticks) begin
            emit            = 1'b1;
            res.status_kind = lpsd_pkg::ST_TIMEOUT;
            phase_nxt       = lpsd_pkg::PH_DONE;
          end
        end
        lpsd_pkg::OP_BYTE: begin
          if (phase_r == lpsd_pkg::PH_LEN) begin
            acc_nxt  = acc_new;
            hidx_nxt = hidx_r + 1'b1;
            if (hidx_r == '1) begin
              if (acc_new == '0) begin
                emit            = 1'b1;
                res.status_kind = lpsd_pkg::ST_END;
                phase_nxt       = lpsd_pkg::PH_DONE;
              end else if (acc_new == lpsd_pkg::FAIL_MARK) begin
                emit            = 1'b1;
                res.status_kind = lpsd_pkg::ST_REMOTE;
                phase_nxt       = lpsd_pkg::PH_DONE;
              end else if (acc_new > {{(lpsd_pkg::LEN_W-lpsd_pkg::FLEN_W){1'b0}},
                                      cfg.max_frame_length}) begin
                emit            = 1'b1;
                res.status_kind = lpsd_pkg::ST_PROTO;
                phase_nxt       = lpsd_pkg::PH_DONE;
              end else begin
                flen_nxt  = acc_new[lpsd_pkg::FLEN_W-1:0];
                rem_nxt   = acc_new[lpsd_pkg::FLEN_W-1:0];
                acc_nxt   = '0;
                idle_nxt  = '0;
                phase_nxt = lpsd_pkg::PH_PAY;
              end
            end
          end else if (phase_r == lpsd_pkg::PH_PAY) begin
            emit             = 1'b1;
            res.payload_byte = beat.data_byte;
            rem_nxt          = rem_dec;
            if (rem_dec == '0) begin
              total_nxt = total_r +
                          {{(lpsd_pkg::TOTAL_W-lpsd_pkg::FLEN_W){1'b0}}, flen_r};
              res.frame_end       = 1'b1;
              res.committed_bytes = total_nxt;
              phase_nxt           = lpsd_pkg::PH_LEN;
              hidx_nxt            = '0;
              acc_nxt             = '0;
              idle_nxt            = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpsd_pkg::PH_LEN;
      hidx_r  <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      flen_r  <= '0;
      idle_r  <= '0;
      total_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      flen_r  <= flen_nxt;
      idle_r  <= idle_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_r <= res;
    end
  end

endmodule

FILE: rtl/length_prefixed_stream_deframer.sv
// Top level: length-prefixed stream deframer.
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  opcode[1:0], data_byte[7:0]
//   out_ch   out  valid/ready  status_kind[2:0], payload_byte[7:0], frame_end,
//                              committed_bytes[31:0]
//   cfg_ch   in   valid/ready  idx[1:0], data[23:0]
//
// One beat per cycle sustained while out_ch is not stalled; a beat's result, if it
// has one, passes through the input register, then the result register.
// Reset (rst_n low, synchronous) empties both registers and loads config defaults.
// A stalled result holds the result register; the input register still takes
// one more beat if it is empty, after which in_ch.ready drops.
`timescale 1ns / 1ps
module length_prefixed_stream_deframer (
  input  logic       clk,
  input  logic       rst_n,
  lpsd_in_if.sink    in_ch,
  lpsd_out_if.source out_ch,
  lpsd_cfg_if.sink   cfg_ch
);

  lpsd_pkg::cfg_t      cfg;
  lpsd_pkg::in_beat_t  in_beat;
  lpsd_pkg::in_beat_t  beat;
  lpsd_pkg::out_beat_t out_beat;
  logic                beat_valid;
  logic                take;

  assign in_beat.opcode    = in_ch.opcode;
  assign in_beat.data_byte = in_ch.data_byte;

  lpsd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_idx   (cfg_ch.idx),
    .wr_data  (cfg_ch.data),
    .wr_ready (cfg_ch.ready),
    .cfg      (cfg)
  );

  lpsd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_beat    (in_beat),
    .in_ready   (in_ch.ready),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  lpsd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .beat_valid (beat_valid),
    .beat       (beat),
    .take       (take),
    .out_valid  (out_ch.valid),
    .out_beat   (out_beat),
    .out_ready  (out_ch.ready)
  );

  assign out_ch.status_kind     = out_beat.status_kind;
  assign out_ch.payload_byte    = out_beat.payload_byte;
  assign out_ch.frame_end       = out_beat.frame_end;
  assign out_ch.committed_bytes = out_beat.committed_bytes;

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a stalled result");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status_kind != lpsd_pkg::ST_BYTE) |->
      (out_ch.payload_byte == '0 && !out_ch.frame_end))
    else $error("final status carries payload fields");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status_kind <= lpsd_pkg::ST_CANCEL))
    else $error("status code out of range");

endmodule
